[hw/rtl/flxrng_pkg.sv]
package flxrng_pkg;

    // Default sizing
    localparam int LANES_DEF     = 4;
    localparam int MAX_BATCH_DEF = 64;

    // SplitMix64 constants
    localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_B  = 64'h94d0_49bb_1331_11eb;

    // Mix shift amounts
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // xoroshiro128++ rotations and shift
    localparam int ROT_OUT = 17;
    localparam int ROT_A   = 49;
    localparam int SHL_B   = 21;
    localparam int ROT_C   = 28;

    // Request codes
    localparam logic [1:0] FUNC_SINGLE = 2'd0;
    localparam logic [1:0] FUNC_BATCH  = 2'd1;
    localparam logic [1:0] FUNC_RESEED = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] count;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_START,
        ST_MIX_WAIT,
        ST_REFILL,
        ST_DRAIN,
        ST_GROUP
    } t_state;

    typedef enum logic [2:0] {
        MX_IDLE,
        MX_M0,
        MX_M1,
        MX_M2,
        MX_M3,
        MX_POST
    } t_mix_state;

    // Bit i set when count i is a whole number of groups (zero excluded)
    function automatic logic [127:0] f_mult_mask(input int lanes);
        logic [127:0] mask;
        int           k;
        mask = '0;
        k    = 0;
        for (int i = 0; i < 128; i++) begin
            mask[i] = (k == 0) && (i != 0);
            k = (k == lanes - 1) ? 0 : k + 1;
        end
        return mask;
    endfunction

    function automatic logic [63:0] f_rotl(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

endpackage

[hw/rtl/flxrng_lane_step.sv]
module flxrng_lane_step
    import flxrng_pkg::*;
(
    input  logic [63:0] i_s0,
    input  logic [63:0] i_s1,
    output logic [63:0] o_value,
    output logic [63:0] o_s0,
    output logic [63:0] o_s1
);

    logic [63:0] sum;
    logic [63:0] t;

    // Output word and state advance of one lane
    always_comb begin
        sum     = i_s0 + i_s1;
        t       = i_s0 ^ i_s1;
        o_value = f_rotl(sum, ROT_OUT) + i_s0;
        o_s0    = f_rotl(i_s0, ROT_A) ^ t ^ (t << SHL_B);
        o_s1    = f_rotl(t, ROT_C);
    end

endmodule

[hw/rtl/flxrng_mix.sv]
module flxrng_mix
    import flxrng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [63:0] o_y
);

    t_mix_state  r_state, n_state;
    logic        r_pass;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [63:0] r_y;

    logic [63:0] k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;

    assign k = r_pass ? MIX_B : MIX_A;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            MX_IDLE: begin
                if (i_start) n_state = MX_M0;
            end
            MX_M0:   n_state = MX_M1;
            MX_M1:   n_state = MX_M2;
            MX_M2:   n_state = MX_M3;
            MX_M3:   n_state = MX_POST;
            MX_POST: n_state = r_pass ? MX_IDLE : MX_M0;
            default: n_state = MX_IDLE;
        endcase
    end

    // Operand select for the shared 32x32 multiplier
    always_comb begin
        case (r_state)
            MX_M0: begin
                mul_a = r_a[31:0];
                mul_b = k[31:0];
            end
            MX_M1: begin
                mul_a = r_a[31:0];
                mul_b = k[63:32];
            end
            MX_M2: begin
                mul_a = r_a[63:32];
                mul_b = k[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MX_IDLE;
            r_pass  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == MX_POST) && r_pass;
            if (r_state == MX_IDLE && i_start) r_pass <= 1'b0;
            else if (r_state == MX_POST)       r_pass <= ~r_pass;
        end
    end

    // Datapath: low 64 bits of a*k from three partial products
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            MX_IDLE: begin
                if (i_start) r_a <= i_x ^ (i_x >> MIX_SH0);
            end
            MX_M1:   r_acc <= r_prod;
            MX_M2:   r_acc <= r_acc + {r_prod[31:0], 32'h0};
            MX_M3:   r_acc <= r_acc + {r_prod[31:0], 32'h0};
            MX_POST: begin
                if (r_pass) r_y <= r_acc ^ (r_acc >> MIX_SH2);
                else        r_a <= r_acc ^ (r_acc >> MIX_SH1);
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

[hw/rtl/four_lane_xoroshiro128pp_rng_unit.sv]
// Reseed: each of the 2*LANES state words passes through the shared mix multiplier,
//   then the result buffer is refilled lane by lane.
// Single value: output register loaded from the buffer in ST_DRAIN, after ST_REFILL
//   when the buffer is empty; the next request is taken back in ST_IDLE.
// Batch of n: one value per cycle unless the output stalls, apart from a tail refill.
// Synchronous active-low reset runs a reseed with seed zero; requests wait until it ends.
module four_lane_xoroshiro128pp_rng_unit
    import flxrng_pkg::*;
#(
    parameter int LANES     = LANES_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RD_W   = $clog2(LANES + 1);
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam logic [127:0] MULT_MASK = f_mult_mask(LANES);

    t_state             r_state, n_state;
    logic [63:0]        r_seed;
    logic [63:0]        r_z, n_z;
    logic [LANE_W-1:0]  r_lane, n_lane;
    logic               r_word, n_word;
    logic [RD_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [63:0]        r_s0  [LANES];
    logic [63:0]        r_s1  [LANES];
    logic [63:0]        r_buf [LANES];
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               in_acc;
    logic               out_free;
    logic [6:0]         cnt;
    logic [CNT_W-1:0]   rem_dec;
    logic               lane_end;
    logic [63:0]        step_value;
    logic [63:0]        step_s0;
    logic [63:0]        step_s1;
    logic               mix_start;
    logic               mix_done;
    logic [63:0]        mix_y;
    logic               emit;
    t_out_item          emit_data;
    logic               state_we;
    logic               mix_we;
    logic               buf_we;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign cnt         = (i_in_data.count > 7'(MAX_BATCH)) ? 7'(MAX_BATCH) : i_in_data.count;
    assign rem_dec     = r_rem - CNT_W'(1);
    assign lane_end    = (32'(r_lane) == LANES - 1);

    // Shared lane step, applied to one lane a cycle unless the output stalls
    flxrng_lane_step u_step (
        .i_s0    (r_s0[r_lane]),
        .i_s1    (r_s1[r_lane]),
        .o_value (step_value),
        .o_s0    (step_s0),
        .o_s1    (step_s1)
    );

    // SplitMix64 finaliser
    flxrng_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_x     (n_z),
        .o_done  (mix_done),
        .o_y     (mix_y)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.func)
                        FUNC_SINGLE: begin
                            n_state = (32'(r_rd) >= LANES) ? ST_REFILL : ST_DRAIN;
                        end
                        FUNC_BATCH: begin
                            if (cnt == '0)              n_state = ST_IDLE;
                            else if (MULT_MASK[cnt])    n_state = ST_GROUP;
                            else if (32'(r_rd) < LANES) n_state = ST_DRAIN;
                            else if (32'(cnt) >= LANES) n_state = ST_GROUP;
                            else                        n_state = ST_REFILL;
                        end
                        FUNC_RESEED: n_state = ST_MIX_START;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MIX_START: n_state = ST_MIX_WAIT;
            ST_MIX_WAIT: begin
                if (mix_done) n_state = (r_word && lane_end) ? ST_REFILL : ST_MIX_START;
            end
            ST_REFILL: begin
                if (lane_end) n_state = (r_rem != '0) ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                if (out_free) begin
                    if (r_rem == CNT_W'(1))            n_state = ST_IDLE;
                    else if (32'(r_rd) + 1 == LANES)
                        n_state = (32'(rem_dec) >= LANES) ? ST_GROUP : ST_REFILL;
                end
            end
            ST_GROUP: begin
                if (out_free) begin
                    if (r_rem == CNT_W'(1))                   n_state = ST_IDLE;
                    else if (lane_end && 32'(rem_dec) < LANES) n_state = ST_REFILL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs and counter updates
    always_comb begin
        n_z       = r_z;
        n_lane    = r_lane;
        n_word    = r_word;
        n_rd      = r_rd;
        n_rem     = r_rem;
        mix_start = 1'b0;
        mix_we    = 1'b0;
        state_we  = 1'b0;
        buf_we    = 1'b0;
        emit      = 1'b0;
        emit_data = '{value: r_buf[r_rd[LANE_W-1:0]], last: (r_rem == CNT_W'(1))};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_lane = '0;
                    n_word = 1'b0;
                    case (i_in_data.func)
                        FUNC_SINGLE: n_rem = CNT_W'(1);
                        FUNC_BATCH: begin
                            n_rem = CNT_W'(cnt);
                            if (MULT_MASK[cnt]) n_rd = RD_W'(LANES);
                        end
                        FUNC_RESEED: begin
                            n_rem = '0;
                            n_z   = r_seed;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MIX_START: begin
                n_z       = r_z + GOLDEN;
                mix_start = 1'b1;
            end
            ST_MIX_WAIT: begin
                if (mix_done) begin
                    mix_we = 1'b1;
                    n_word = ~r_word;
                    if (r_word) n_lane = lane_end ? '0 : r_lane + LANE_W'(1);
                end
            end
            ST_REFILL: begin
                state_we = 1'b1;
                buf_we   = 1'b1;
                n_lane   = lane_end ? '0 : r_lane + LANE_W'(1);
                if (lane_end) n_rd = '0;
            end
            ST_DRAIN: begin
                if (out_free) begin
                    emit  = 1'b1;
                    n_rd  = r_rd + RD_W'(1);
                    n_rem = rem_dec;
                end
            end
            ST_GROUP: begin
                emit_data.value = step_value;
                if (out_free) begin
                    emit     = 1'b1;
                    state_we = 1'b1;
                    n_rem    = rem_dec;
                    n_lane   = lane_end ? '0 : r_lane + LANE_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers; reset starts a reseed from seed zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_MIX_START;
            r_seed      <= '0;
            r_z         <= '0;
            r_lane      <= '0;
            r_word      <= 1'b0;
            r_rd        <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_z         <= n_z;
            r_lane      <= n_lane;
            r_word      <= n_word;
            r_rd        <= n_rd;
            r_rem       <= n_rem;
            r_out_valid <= emit || (r_out_valid && i_out_stall);
            if (i_cfg_valid && o_cfg_ready) r_seed <= i_cfg_data;
        end
    end

    // Lane state, result buffer and output beat
    always_ff @(posedge i_clk) begin
        if (mix_we) begin
            if (r_word) r_s1[r_lane] <= mix_y;
            else        r_s0[r_lane] <= mix_y;
        end else if (state_we) begin
            r_s0[r_lane] <= step_s0;
            r_s1[r_lane] <= step_s1;
        end
        if (buf_we) r_buf[r_lane] <= step_value;
        if (emit)   r_out_data   <= emit_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
